// ===== hw/rtl/lkpf_pkg.sv =====
// Shared types, constants and frame tables of the lens keypad to Pelco-D frame unit.
package lkpf_pkg;

   localparam int NUM_DIR_KEYS_DEFAULT = 4;
   localparam int KEY_W = 3;
   localparam int CNT_W = 6;
   localparam int FRAME_LEN = 7;
   localparam int FRAME_CNT_W = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   localparam logic [CSR_INDEX_W-1:0] CSR_DOME_ADDRESS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIR_LONG_LIMIT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE_LONG_LIMIT = 2'd2;

   localparam logic [7:0] DOME_ADDRESS_RESET = 8'd1;
   localparam logic [CNT_W-1:0] DIR_LONG_LIMIT_RESET = 6'd30;
   localparam logic [CNT_W-1:0] MODE_LONG_LIMIT_RESET = 6'd40;

   localparam logic [KEY_W-1:0] NO_KEY = 3'd0;
   localparam logic [KEY_W-1:0] KEY_FOCUS_NEAR = 3'd1;
   localparam logic [KEY_W-1:0] KEY_ZOOM_OUT = 3'd2;
   localparam logic [KEY_W-1:0] KEY_ZOOM_IN = 3'd3;
   localparam logic [KEY_W-1:0] KEY_FOCUS_FAR = 3'd4;

   localparam logic [7:0] FRAME_SYNC = 8'hFF;
   localparam logic [7:0] PRESET_ADDR = 8'hFF;
   localparam logic [7:0] CMD_PRESET_CALL = 8'h07;
   localparam logic [7:0] CMD1_FOCUS_NEAR = 8'h01;
   localparam logic [7:0] CMD2_ZOOM_IN = 8'h20;
   localparam logic [7:0] CMD2_ZOOM_OUT = 8'h40;
   localparam logic [7:0] CMD2_FOCUS_FAR = 8'h80;

   typedef enum logic [1:0] {
      EV_NONE,
      EV_PRESS,
      EV_RELEASE,
      EV_LONG
   } ev_kind_type;

   typedef struct packed {
      ev_kind_type      kind;
      logic [KEY_W-1:0] key;
   } dir_event_type;

   typedef struct packed {
      logic [3:0] dir_first;
      logic [3:0] dir_confirm;
      logic       mode_first;
      logic       mode_confirm;
   } sample_type;

   typedef struct packed {
      logic          send;
      logic          preset;
      dir_event_type ev;
   } frame_req_type;

   typedef struct packed {
      logic                   free;
      logic [FRAME_CNT_W-1:0] count;
   } frame_status_type;

   typedef logic [FRAME_LEN-1:0][7:0] frame_bytes_type;

   function automatic logic [7:0] preset_number(dir_event_type ev);
      logic [7:0] p;
      case (ev.key)
         KEY_FOCUS_NEAR: p = 8'd203;
         KEY_ZOOM_OUT: p = 8'd202;
         KEY_ZOOM_IN: p = 8'd201;
         KEY_FOCUS_FAR: p = 8'd204;
         default: p = 8'd0;
      endcase
      if (ev.kind == EV_LONG) begin
         p = p + 8'd4;
      end
      return p;
   endfunction

endpackage

// ===== hw/rtl/lkpf_key_scan.sv =====
// Key event tracking, combo lock and frame request decision, one scan beat per step.
module lkpf_key_scan
   import lkpf_pkg::*;
#(
   parameter int NUM_DIR_KEYS = NUM_DIR_KEYS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  sample_type       sample,
   input  logic [CNT_W-1:0] dir_long_limit,
   input  logic [CNT_W-1:0] mode_long_limit,
   output frame_req_type    frame_req
);

   logic [KEY_W-1:0] dir_held_key_ff, dir_held_key_in;
   logic [CNT_W-1:0] dir_hold_count_ff, dir_hold_count_in;
   logic             dir_long_seen_ff, dir_long_seen_in;
   logic             mode_held_ff, mode_held_in;
   logic [CNT_W-1:0] mode_hold_count_ff, mode_hold_count_in;
   logic             mode_long_seen_ff, mode_long_seen_in;
   logic             combo_active_ff, combo_active_in;
   logic             last_valid_ff, last_valid_in;
   dir_event_type    last_event_ff, last_event_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_held_key_ff <= NO_KEY;
         dir_hold_count_ff <= '0;
         dir_long_seen_ff <= 1'b0;
         mode_held_ff <= 1'b0;
         mode_hold_count_ff <= '0;
         mode_long_seen_ff <= 1'b0;
         combo_active_ff <= 1'b0;
         last_valid_ff <= 1'b0;
         last_event_ff <= '{kind: EV_NONE, key: NO_KEY};
      end else if (step) begin
         dir_held_key_ff <= dir_held_key_in;
         dir_hold_count_ff <= dir_hold_count_in;
         dir_long_seen_ff <= dir_long_seen_in;
         mode_held_ff <= mode_held_in;
         mode_hold_count_ff <= mode_hold_count_in;
         mode_long_seen_ff <= mode_long_seen_in;
         combo_active_ff <= combo_active_in;
         last_valid_ff <= last_valid_in;
         last_event_ff <= last_event_in;
      end
   end

   always_comb begin
      ev_kind_type      mode_ev;
      dir_event_type    dir_ev;
      logic             mode_pressed;
      logic             found;
      logic [KEY_W-1:0] hit_key;

      mode_held_in = mode_held_ff;
      mode_hold_count_in = mode_hold_count_ff;
      mode_long_seen_in = mode_long_seen_ff;
      dir_held_key_in = dir_held_key_ff;
      dir_hold_count_in = dir_hold_count_ff;
      dir_long_seen_in = dir_long_seen_ff;
      combo_active_in = combo_active_ff;
      last_valid_in = last_valid_ff;
      last_event_in = last_event_ff;
      mode_ev = EV_NONE;
      dir_ev = '{kind: EV_NONE, key: NO_KEY};
      frame_req = '{send: 1'b0, preset: 1'b0, ev: '{kind: EV_NONE, key: NO_KEY}};

      // mode key
      mode_pressed = !sample.mode_first && !sample.mode_confirm;
      if (mode_pressed) begin
         if (mode_held_ff && (mode_hold_count_ff > mode_long_limit)) begin
            if (!mode_long_seen_ff) begin
               mode_long_seen_in = 1'b1;
               mode_hold_count_in = '0;
               mode_held_in = 1'b0;
               mode_ev = EV_LONG;
            end
         end else begin
            if (mode_held_ff && (mode_hold_count_ff != CNT_MAX)) begin
               mode_hold_count_in = mode_hold_count_ff + 1'b1;
            end
            mode_held_in = 1'b1;
            mode_ev = EV_PRESS;
         end
      end else if (mode_held_ff) begin
         mode_held_in = 1'b0;
         if (mode_long_seen_ff) begin
            mode_long_seen_in = 1'b0;
         end else begin
            mode_ev = EV_RELEASE;
         end
      end

      // direction keys, lowest pressed key wins
      found = 1'b0;
      hit_key = NO_KEY;
      for (int i = 0; i < NUM_DIR_KEYS; i++) begin
         if (!found && !sample.dir_first[i] && !sample.dir_confirm[i]) begin
            found = 1'b1;
            hit_key = KEY_W'(i + 1);
         end
      end

      if (found) begin
         if (dir_held_key_ff == hit_key) begin
            if (mode_held_in) begin
               if (dir_hold_count_ff > dir_long_limit) begin
                  if (!dir_long_seen_ff) begin
                     dir_long_seen_in = 1'b1;
                     dir_hold_count_in = '0;
                     dir_held_key_in = NO_KEY;
                     dir_ev = '{kind: EV_LONG, key: hit_key};
                  end
               end else if (dir_hold_count_ff != CNT_MAX) begin
                  dir_hold_count_in = dir_hold_count_ff + 1'b1;
               end
            end else begin
               dir_ev = '{kind: EV_PRESS, key: hit_key};
            end
         end else begin
            dir_held_key_in = hit_key;
         end
      end else if (dir_held_key_ff != NO_KEY) begin
         dir_held_key_in = NO_KEY;
         if (dir_long_seen_ff) begin
            dir_long_seen_in = 1'b0;
         end else begin
            dir_ev = '{kind: EV_RELEASE, key: dir_held_key_ff};
         end
      end

      // frame decision
      if ((mode_ev != EV_NONE) || mode_long_seen_in) begin
         combo_active_in = 1'b1;
         frame_req.preset = 1'b1;
         frame_req.ev = dir_ev;
         frame_req.send = (dir_ev.kind == EV_RELEASE) || (dir_ev.kind == EV_LONG);
      end else if (dir_ev.kind != EV_NONE) begin
         if (combo_active_ff) begin
            if (last_valid_ff && (last_event_ff != dir_ev)) begin
               combo_active_in = 1'b0;
            end
         end else begin
            frame_req.ev = dir_ev;
            frame_req.send = (dir_ev.kind == EV_PRESS) || (dir_ev.kind == EV_RELEASE);
         end
         last_valid_in = 1'b1;
         last_event_in = dir_ev;
      end
   end

endmodule

// ===== hw/rtl/lkpf_frame_build.sv =====
// Frame byte table and additive checksum for one frame request.
module lkpf_frame_build
   import lkpf_pkg::*;
(
   input  frame_req_type   frame_req,
   input  logic [7:0]      dome_address,
   output frame_bytes_type frame_bytes
);

   always_comb begin
      logic [7:0] addr, cmd1, cmd2, data1, data2;
      addr = dome_address;
      cmd1 = 8'h00;
      cmd2 = 8'h00;
      data1 = 8'h00;
      data2 = 8'h00;
      if (frame_req.preset) begin
         addr = PRESET_ADDR;
         cmd2 = CMD_PRESET_CALL;
         data2 = preset_number(frame_req.ev);
      end else if (frame_req.ev.kind == EV_PRESS) begin
         case (frame_req.ev.key)
            KEY_FOCUS_NEAR: cmd1 = CMD1_FOCUS_NEAR;
            KEY_ZOOM_OUT: cmd2 = CMD2_ZOOM_OUT;
            KEY_ZOOM_IN: cmd2 = CMD2_ZOOM_IN;
            KEY_FOCUS_FAR: cmd2 = CMD2_FOCUS_FAR;
            default: cmd2 = 8'h00;
         endcase
      end
      frame_bytes[0] = FRAME_SYNC;
      frame_bytes[1] = addr;
      frame_bytes[2] = cmd1;
      frame_bytes[3] = cmd2;
      frame_bytes[4] = data1;
      frame_bytes[5] = data2;
      frame_bytes[6] = addr + cmd1 + cmd2 + data1 + data2;
   end

endmodule

// ===== hw/rtl/lkpf_frame_out.sv =====
// Frame holding register that sends a loaded frame out one byte per beat.
module lkpf_frame_out
   import lkpf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  frame_bytes_type  frame_bytes,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tlast,
   output frame_status_type status
);

   frame_bytes_type        bytes_ff, bytes_in;
   logic [FRAME_CNT_W-1:0] count_ff, count_in;
   logic                   take;

   assign take = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata = bytes_ff[0];
   assign rsp_tlast = (count_ff == FRAME_CNT_W'(1));
   assign status.free = !rsp_tvalid || (rsp_tlast && rsp_tready);
   assign status.count = count_ff;

   always_comb begin
      bytes_in = bytes_ff;
      count_in = count_ff;
      if (load) begin
         bytes_in = frame_bytes;
         count_in = FRAME_CNT_W'(FRAME_LEN);
      end else if (take) begin
         bytes_in = {8'h00, bytes_ff[FRAME_LEN-1:1]};
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
   end

endmodule

// ===== hw/rtl/lens_keypad_to_pelco_frames_unit.sv =====
// Top level of the lens keypad to Pelco-D frame unit.
//
// One req beat is one key scan: first and confirming active-low samples of
// the direction keys and the mode key. Each scan updates the key trackers
// and emits either nothing or one seven-byte Pelco-D frame on rsp, one byte
// per beat, byte 0 first, rsp_tlast on the checksum byte.
// A scan is captured in the input register, decoded combinationally from it
// and loaded into the output shift register, which presents the frame bytes.
// Scans that give no frame go at one per cycle while that register is empty;
// a scan that gives a frame fills it with its seven bytes, which leave one per
// taken beat, the next frame loading as the last byte is taken.
// When rsp stalls, the frame holds, the input register fills and req_tready
// drops until the frame drains.
// csr writes (index 0 dome address, 1 direction long limit, 2 mode long
// limit) take effect at once and should be made while idle.
// Reset (synchronous) clears all key trackers, empties both registers and
// loads the register defaults 1, 30 and 40.
module lens_keypad_to_pelco_frames_unit
   import lkpf_pkg::*;
#(
   parameter int NUM_DIR_KEYS = NUM_DIR_KEYS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [3:0] dir_keys_first, [7:4] dir_keys_confirm, [8] mode_key_first,
   // [9] mode_key_confirm, [15:10] zero
   input  logic [15:0]            req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [7:0] frame_byte
   output logic [7:0]             rsp_tdata,
   output logic                   rsp_tlast,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [7:0]       dome_address_ff;
   logic [CNT_W-1:0] dir_long_limit_ff;
   logic [CNT_W-1:0] mode_long_limit_ff;

   logic             in_valid_ff, in_valid_in;
   sample_type       sample_ff, sample_in;
   logic             advance;
   logic             frame_load;

   frame_req_type    frame_req;
   frame_bytes_type  frame_bytes;
   frame_status_type frame_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         dome_address_ff <= DOME_ADDRESS_RESET;
         dir_long_limit_ff <= DIR_LONG_LIMIT_RESET;
         mode_long_limit_ff <= MODE_LONG_LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DOME_ADDRESS: dome_address_ff <= csr_wdata[7:0];
            CSR_DIR_LONG_LIMIT: dir_long_limit_ff <= csr_wdata[CNT_W-1:0];
            CSR_MODE_LONG_LIMIT: mode_long_limit_ff <= csr_wdata[CNT_W-1:0];
            default: dome_address_ff <= dome_address_ff;
         endcase
      end
   end

   assign advance = in_valid_ff && frame_status.free;
   assign frame_load = advance && frame_req.send;
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      sample_in = sample_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         sample_in.dir_first = req_tdata[3:0];
         sample_in.dir_confirm = req_tdata[7:4];
         sample_in.mode_first = req_tdata[8];
         sample_in.mode_confirm = req_tdata[9];
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
   end

   lkpf_key_scan #(
      .NUM_DIR_KEYS(NUM_DIR_KEYS)
   ) u_key_scan (
      .clock(clock),
      .reset(reset),
      .step(advance),
      .sample(sample_ff),
      .dir_long_limit(dir_long_limit_ff),
      .mode_long_limit(mode_long_limit_ff),
      .frame_req(frame_req)
   );

   lkpf_frame_build u_frame_build (
      .frame_req(frame_req),
      .dome_address(dome_address_ff),
      .frame_bytes(frame_bytes)
   );

   lkpf_frame_out u_frame_out (
      .clock(clock),
      .reset(reset),
      .load(frame_load),
      .frame_bytes(frame_bytes),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .status(frame_status)
   );

   a_load_starts_frame: assert property (@(posedge clock) disable iff (reset)
      frame_load |=> (rsp_tvalid && !rsp_tlast && (rsp_tdata == FRAME_SYNC)))
      else $error("frame load did not present a sync byte");

   a_frame_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast && !frame_load) |=> !rsp_tvalid)
      else $error("output still valid after last byte");

   a_held_scan: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(sample_ff)))
      else $error("stalled scan lost or changed");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      frame_status.count <= FRAME_CNT_W'(FRAME_LEN))
      else $error("frame byte count out of range");

endmodule
